@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ELC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ELC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/elc_pkg.sv @@
// Types and fixed widths shared by the line construction datapath.
package elc_pkg;

	localparam int COORD_W  = 32;
	localparam int MAG_W    = 33;
	localparam int FIT_W    = 31;
	localparam int ROOT_W   = 32;
	localparam int RAD_W    = 64;
	localparam int SQ_STEPS = 32;
	localparam int MIN_W    = 16;
	localparam int SUM_W    = 34;

	typedef enum logic [1:0] {
		KIND_PERP_BISECT,
		KIND_ANGLE_BISECT,
		KIND_PARALLEL,
		KIND_PERP_THROUGH
	} kind_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
		logic             neg_x;
		logic             neg_y;
	} norm_in_t;

endpackage

@@ rtl/elc_norm.sv @@
// Pipelined vector normalizer: range fit, squares, square root and two dividers.
module elc_norm import elc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        en,
	input  norm_in_t                    vec,
	input  logic [MIN_W-1:0]            min_len,
	input  logic                        use_min,
	output logic signed [FRAC_BITS+1:0] ux,
	output logic signed [FRAC_BITS+1:0] uy,
	output logic                        ok
);

	localparam int QW = FRAC_BITS + 1;
	localparam int NW = ROOT_W + FRAC_BITS;
	localparam int UW = FRAC_BITS + 2;

	typedef struct packed {
		logic [FIT_W-1:0] mx;
		logic [FIT_W-1:0] my;
		logic             full;
		logic             neg_x;
		logic             neg_y;
	} side_t;

	logic [1:0]       sh;
	logic [MAG_W-1:0] shx, shy;
	side_t            side_s0, side_s1, side_s2;
	logic [2*FIT_W-1:0] sqx_s1, sqy_s1;
	logic [RAD_W-1:0] rad_s2;

	// A component of 2^31 or more forces both down by the same shift.
	always_comb begin
		if (vec.mag_x[MAG_W-1] || vec.mag_y[MAG_W-1]) begin
			sh = 2'd2;
		end else if (vec.mag_x[MAG_W-2] || vec.mag_y[MAG_W-2]) begin
			sh = 2'd1;
		end else begin
			sh = 2'd0;
		end
		shx = vec.mag_x >> sh;
		shy = vec.mag_y >> sh;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s0 <= '{mx: shx[FIT_W-1:0], my: shy[FIT_W-1:0], full: (sh == 2'd0),
				neg_x: vec.neg_x, neg_y: vec.neg_y};
			side_s1 <= side_s0;
			sqx_s1  <= side_s0.mx * side_s0.mx;
			sqy_s1  <= side_s0.my * side_s0.my;
			side_s2 <= side_s1;
			rad_s2  <= RAD_W'(sqx_s1) + RAD_W'(sqy_s1);
		end
	end

	// Square root, one result bit per stage.
	logic [RAD_W-1:0]    sq_rad_s  [0:SQ_STEPS];
	logic [ROOT_W+1:0]   sq_rem_s  [0:SQ_STEPS];
	logic [ROOT_W-1:0]   sq_root_s [0:SQ_STEPS];
	side_t               sq_side_s [0:SQ_STEPS];

	assign sq_rad_s[0]  = rad_s2;
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;
	assign sq_side_s[0] = side_s2;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
		logic [ROOT_W+3:0] t;
		logic [ROOT_W+1:0] trial;
		logic              ge;
		assign t     = {sq_rem_s[i], sq_rad_s[i][RAD_W-1-2*i -: 2]};
		assign trial = {sq_root_s[i], 2'b01};
		assign ge    = (t >= (ROOT_W+4)'(trial));
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_s[i+1]  <= sq_rad_s[i];
				sq_rem_s[i+1]  <= ge ? (ROOT_W+2)'(t - (ROOT_W+4)'(trial)) : (ROOT_W+2)'(t);
				sq_root_s[i+1] <= {sq_root_s[i][ROOT_W-2:0], ge};
				sq_side_s[i+1] <= sq_side_s[i];
			end
		end
	end

	// Degenerate check and rounded numerators.
	logic [ROOT_W-1:0] len;
	side_t             fin;
	logic [NW-1:0]     dv_remx_s [0:QW];
	logic [NW-1:0]     dv_remy_s [0:QW];
	logic [ROOT_W-1:0] dv_len_s  [0:QW];
	logic [QW-1:0]     dv_qx_s   [0:QW];
	logic [QW-1:0]     dv_qy_s   [0:QW];
	logic              dv_ok_s   [0:QW];
	logic              dv_nx_s   [0:QW];
	logic              dv_ny_s   [0:QW];

	assign len = sq_root_s[SQ_STEPS];
	assign fin = sq_side_s[SQ_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_ok_s[0]   <= (len != '0) &&
				!(use_min && fin.full && (len < ROOT_W'(min_len)));
			dv_remx_s[0] <= (NW'(fin.mx) << FRAC_BITS) + NW'(len >> 1);
			dv_remy_s[0] <= (NW'(fin.my) << FRAC_BITS) + NW'(len >> 1);
			dv_len_s[0]  <= len;
			dv_qx_s[0]   <= '0;
			dv_qy_s[0]   <= '0;
			dv_nx_s[0]   <= fin.neg_x;
			dv_ny_s[0]   <= fin.neg_y;
		end
	end

	// Restoring division, one quotient bit per stage, most significant first.
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [NW-1:0] dsh;
		logic          gx, gy;
		assign dsh = NW'(dv_len_s[j]) << (QW - 1 - j);
		assign gx  = (dv_remx_s[j] >= dsh);
		assign gy  = (dv_remy_s[j] >= dsh);
		always_ff @(posedge clk) begin
			if (en) begin
				dv_remx_s[j+1] <= gx ? dv_remx_s[j] - dsh : dv_remx_s[j];
				dv_remy_s[j+1] <= gy ? dv_remy_s[j] - dsh : dv_remy_s[j];
				dv_qx_s[j+1]   <= {dv_qx_s[j][QW-2:0], gx};
				dv_qy_s[j+1]   <= {dv_qy_s[j][QW-2:0], gy};
				dv_len_s[j+1]  <= dv_len_s[j];
				dv_ok_s[j+1]   <= dv_ok_s[j];
				dv_nx_s[j+1]   <= dv_nx_s[j];
				dv_ny_s[j+1]   <= dv_ny_s[j];
			end
		end
	end

	logic signed [UW-1:0] ux_q, uy_q;
	logic                 ok_q;

	always_ff @(posedge clk) begin
		if (en) begin
			ux_q <= dv_nx_s[QW] ? -UW'(dv_qx_s[QW]) : UW'(dv_qx_s[QW]);
			uy_q <= dv_ny_s[QW] ? -UW'(dv_qy_s[QW]) : UW'(dv_qy_s[QW]);
			ok_q <= dv_ok_s[QW];
		end
	end

	assign ux = ux_q;
	assign uy = uy_q;
	assign ok = ok_q;

endmodule

@@ rtl/extended_line_construction_unit.sv @@
// Top level of the line construction pipeline: perpendicular bisector, angle bisector,
// parallel line and perpendicular through a point.
//  Channel   Direction  Handshake           Contents
//  s_*       in         s_tvalid/s_tready   kind (tuser), points A, B, C (tdata)
//  m_*       out        m_tvalid/m_tready   valid_res (tuser), two line points (tdata)
//  cfg_*     in         cfg_we              min_length register
//
// One item enters per cycle while not held. Path: input register, two normalizers in
// series, each with a 32-stage square root and a FRAC_BITS + 1 stage divider, output
// register. The whole pipeline advances together; it holds only while a result sits
// in the output register and the sink is not ready, and then nothing is lost.
// Reset clears the valid bits and sets min_length to 1; no clearing pass is needed.
module extended_line_construction_unit import elc_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y
	input  logic [6*COORD_W-1:0] s_tdata,
	// kind
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// first_x, first_y, second_x, second_y
	output logic [4*COORD_W-1:0] m_tdata,
	// valid_res
	output logic [0:0]           m_tuser,
	input  logic                 cfg_we,
	input  logic [MIN_W-1:0]     cfg_wdata
);

	// Latency of one normalizer, counted from its input to its registered output.
	localparam int NLAT = FRAC_BITS + 38;
	localparam int UW   = FRAC_BITS + 2;

	typedef struct packed {
		kind_t                      kind;
		logic signed [COORD_W-1:0]  px;
		logic signed [COORD_W-1:0]  py;
	} line1_t;

	typedef struct packed {
		kind_t                      kind;
		logic signed [COORD_W-1:0]  px;
		logic signed [COORD_W-1:0]  py;
		logic signed [UW-1:0]       u1x;
		logic signed [UW-1:0]       u1y;
		logic                       ok;
		logic                       anti;
	} line2_t;

	// The pipeline moves whenever the output register can take a new item.
	logic en;
	logic m_tvalid_q;
	assign en       = m_tready || !m_tvalid_q;
	assign s_tready = en;

	logic [MIN_W-1:0] min_length_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_W'(1);
		end else if (cfg_we) begin
			min_length_q <= cfg_wdata;
		end
	end

	// Input register.
	logic                      vld_s1;
	kind_t                     kind_s1;
	logic signed [COORD_W-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind_t'(s_tuser);
			ax_s1   <= s_tdata[0*COORD_W +: COORD_W];
			ay_s1   <= s_tdata[1*COORD_W +: COORD_W];
			bx_s1   <= s_tdata[2*COORD_W +: COORD_W];
			by_s1   <= s_tdata[3*COORD_W +: COORD_W];
			cx_s1   <= s_tdata[4*COORD_W +: COORD_W];
			cy_s1   <= s_tdata[5*COORD_W +: COORD_W];
		end
	end

	function automatic norm_in_t to_norm(logic signed [MAG_W-1:0] dx,
			logic signed [MAG_W-1:0] dy);
		norm_in_t r;
		r.neg_x = dx[MAG_W-1];
		r.neg_y = dy[MAG_W-1];
		r.mag_x = dx[MAG_W-1] ? -dx : dx;
		r.mag_y = dy[MAG_W-1] ? -dy : dy;
		return r;
	endfunction

	// Difference vectors and base point. The angle bisector uses rays BA and BC;
	// every other kind takes its direction from AB.
	logic signed [MAG_W-1:0] d1x, d1y, d2x, d2y, sumx, sumy;
	norm_in_t                n1_in, n2_in;
	line1_t                  l1_in;

	always_comb begin
		d2x  = MAG_W'(cx_s1) - MAG_W'(bx_s1);
		d2y  = MAG_W'(cy_s1) - MAG_W'(by_s1);
		sumx = MAG_W'(ax_s1) + MAG_W'(bx_s1);
		sumy = MAG_W'(ay_s1) + MAG_W'(by_s1);
		l1_in.kind = kind_s1;
		case (kind_s1)
			KIND_PERP_BISECT: begin
				d1x      = MAG_W'(bx_s1) - MAG_W'(ax_s1);
				d1y      = MAG_W'(by_s1) - MAG_W'(ay_s1);
				// Arithmetic shift of the sum rounds the midpoint toward minus infinity.
				l1_in.px = sumx[MAG_W-1:1];
				l1_in.py = sumy[MAG_W-1:1];
			end
			KIND_ANGLE_BISECT: begin
				d1x      = MAG_W'(ax_s1) - MAG_W'(bx_s1);
				d1y      = MAG_W'(ay_s1) - MAG_W'(by_s1);
				l1_in.px = bx_s1;
				l1_in.py = by_s1;
			end
			default: begin
				d1x      = MAG_W'(bx_s1) - MAG_W'(ax_s1);
				d1y      = MAG_W'(by_s1) - MAG_W'(ay_s1);
				l1_in.px = cx_s1;
				l1_in.py = cy_s1;
			end
		endcase
		n1_in = to_norm(d1x, d1y);
		n2_in = to_norm(d2x, d2y);
	end

	logic signed [UW-1:0] u1x, u1y, u2x, u2y, u3x, u3y;
	logic                 ok1, ok2, ok3;

	elc_norm #(.FRAC_BITS(FRAC_BITS)) u_norm1 (
		.clk(clk), .en(en), .vec(n1_in), .min_len(min_length_q), .use_min(1'b1),
		.ux(u1x), .uy(u1y), .ok(ok1)
	);

	elc_norm #(.FRAC_BITS(FRAC_BITS)) u_norm2 (
		.clk(clk), .en(en), .vec(n2_in), .min_len(min_length_q), .use_min(1'b1),
		.ux(u2x), .uy(u2y), .ok(ok2)
	);

	// First delay line keeps the base point beside the first two normalizers.
	line1_t l1_s [0:NLAT];
	logic   v1_s [0:NLAT];
	assign l1_s[0] = l1_in;
	assign v1_s[0] = vld_s1;

	for (genvar k = 0; k < NLAT; k++) begin : g_l1
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v1_s[k+1] <= 1'b0;
			end else if (en) begin
				v1_s[k+1] <= v1_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				l1_s[k+1] <= l1_s[k];
			end
		end
	end

	// Bisector direction: sum of the two ray units. A sum shorter than two raw
	// units means the rays point in opposite directions.
	logic signed [UW:0] bsx, bsy;
	norm_in_t           n3_in;
	line2_t             l2_in;

	always_comb begin
		bsx        = (UW+1)'(u1x) + (UW+1)'(u2x);
		bsy        = (UW+1)'(u1y) + (UW+1)'(u2y);
		n3_in      = to_norm(MAG_W'(bsx), MAG_W'(bsy));
		l2_in.kind = l1_s[NLAT].kind;
		l2_in.px   = l1_s[NLAT].px;
		l2_in.py   = l1_s[NLAT].py;
		l2_in.u1x  = u1x;
		l2_in.u1y  = u1y;
		l2_in.ok   = ok1 && ((l1_s[NLAT].kind != KIND_ANGLE_BISECT) || ok2);
		l2_in.anti = (n3_in.mag_x <= MAG_W'(1)) && (n3_in.mag_y <= MAG_W'(1));
	end

	elc_norm #(.FRAC_BITS(FRAC_BITS)) u_norm3 (
		.clk(clk), .en(en), .vec(n3_in), .min_len(min_length_q), .use_min(1'b0),
		.ux(u3x), .uy(u3y), .ok(ok3)
	);

	// Second delay line runs beside the bisector normalizer.
	line2_t l2_s [0:NLAT];
	logic   v2_s [0:NLAT];
	assign l2_s[0] = l2_in;
	assign v2_s[0] = v1_s[NLAT];

	for (genvar k = 0; k < NLAT; k++) begin : g_l2
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v2_s[k+1] <= 1'b0;
			end else if (en) begin
				v2_s[k+1] <= v2_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				l2_s[k+1] <= l2_s[k];
			end
		end
	end

	function automatic logic [COORD_W-1:0] sat32(logic signed [SUM_W-1:0] v);
		if (v[SUM_W-1:COORD_W-1] == '0 || v[SUM_W-1:COORD_W-1] == '1) begin
			return v[COORD_W-1:0];
		end
		return v[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	// Final direction choice, the two points, saturation.
	line2_t                f;
	logic signed [UW-1:0]  dirx, diry;
	logic                  fin_ok;
	logic [4*COORD_W-1:0]  res;

	always_comb begin
		f = l2_s[NLAT];
		case (f.kind)
			KIND_PERP_BISECT, KIND_PERP_THROUGH: begin
				dirx = -f.u1y;
				diry = f.u1x;
			end
			KIND_ANGLE_BISECT: begin
				dirx = f.anti ? -f.u1y : u3x;
				diry = f.anti ? f.u1x : u3y;
			end
			default: begin
				dirx = f.u1x;
				diry = f.u1y;
			end
		endcase
		// The bisector normalizer cannot fail once the rays are not antiparallel.
		fin_ok = f.ok && ((f.kind != KIND_ANGLE_BISECT) || f.anti || ok3);
		res    = {sat32(SUM_W'($signed(f.py)) - SUM_W'(diry)),
			sat32(SUM_W'($signed(f.px)) - SUM_W'(dirx)),
			sat32(SUM_W'($signed(f.py)) + SUM_W'(diry)),
			sat32(SUM_W'($signed(f.px)) + SUM_W'(dirx))};
	end

	logic [4*COORD_W-1:0] m_tdata_q;
	logic                 valid_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= v2_s[NLAT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q   <= fin_ok ? res : '0;
			valid_res_q <= fin_ok;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = valid_res_q;

endmodule

@@ rtl/elc_checker.sv @@
// Port-level checker for the line construction unit, with its bind.
`include "assert_macros.svh"

module elc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [0:0]   m_tuser
);

	`ELC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output item changed while stalled")
	`ELC_ASSERT(a_bad_zero, m_tvalid && !m_tuser[0] |-> m_tdata == '0, "invalid result carries nonzero points")
	`ELC_ASSERT(a_ready, s_tready == (m_tready || !m_tvalid), "input ready does not follow output space")
	// The valid bit is only known to be clear once a clock edge has seen reset.
	`ELC_ASSERT_ALWAYS(a_rst_idle, !arst_n |=> !m_tvalid, "output valid during reset")

endmodule

bind extended_line_construction_unit elc_checker u_elc_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for the extended line construction unit.
`timescale 1ns / 1ps

module testbench;
	import elc_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = 2 * (FRAC + 38) + 2;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PER_PHASE = 250;
	localparam int PHASES = 8;
	localparam int HOLD_CYCLES = 400;

	// One construction request: kind plus points A, B and C.
	typedef struct {
		kind_t       kind;
		logic [31:0] ax, ay, bx, by, cx, cy;
	} construction_t;

	// One constructed line: validity and the two points on it.
	typedef struct {
		logic        ok;
		logic [31:0] fx, fy, sx, sy;
	} line_pts_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [6*COORD_W-1:0] s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [4*COORD_W-1:0] m_tdata;
	logic [0:0]           m_tuser;
	logic                 cfg_we = 1'b0;
	logic [MIN_W-1:0]     cfg_wdata = '0;

	construction_t pending_requests[$];
	line_pts_t     expected_lines[$];
	longint unsigned min_len = 1;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  phase_no = 0;
	bit  took_item = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_left = 0;
	int  cycles = 0;
	int  mismatches = 0;
	int  lines_checked = 0;
	int  invalid_lines = 0;
	int  kind_count[4] = '{0, 0, 0, 0};

	extended_line_construction_unit #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic longint unsigned abs64(input longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// Rounded unit component, halves away from zero, sign taken from the vector.
	function automatic longint scale_comp(input longint d, input longint unsigned m,
			input longint unsigned len);
		longint q;
		q = longint'(((m << FRAC) + len / 2) / len);
		return d < 0 ? -q : q;
	endfunction

	// Unit vector of (dx,dy); returns 0 when the vector is degenerate.
	function automatic bit unit_vector(input longint dx, input longint dy,
			input longint unsigned minlen, output longint ux, output longint uy);
		longint unsigned mx, my, len;
		int sh;
		ux = 0;
		uy = 0;
		mx = abs64(dx);
		my = abs64(dy);
		sh = 0;
		while ((mx >> sh) >= 64'h8000_0000 || (my >> sh) >= 64'h8000_0000) sh++;
		mx >>= sh;
		my >>= sh;
		len = int_sqrt(mx * mx + my * my);
		if (len == 0) return 1'b0;
		if (sh == 0 && len < minlen) return 1'b0;
		ux = scale_comp(dx, mx, len);
		uy = scale_comp(dy, my, len);
		return 1'b1;
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic line_pts_t construct_line(input construction_t c);
		line_pts_t r;
		longint ax, ay, bx, by, cx, cy, px, py, dx, dy, t;
		longint uax, uay, ucx, ucy, sumx, sumy;
		bit ok, ok2;
		ax = longint'($signed(c.ax)); ay = longint'($signed(c.ay));
		bx = longint'($signed(c.bx)); by = longint'($signed(c.by));
		cx = longint'($signed(c.cx)); cy = longint'($signed(c.cy));
		dx = 0; dy = 0;
		case (c.kind)
			KIND_PERP_BISECT: begin
				// Midpoint rounds toward minus infinity, direction is AB turned left.
				px = (ax + bx) >>> 1;
				py = (ay + by) >>> 1;
				ok = unit_vector(bx - ax, by - ay, min_len, dx, dy);
				t = dx; dx = -dy; dy = t;
			end
			KIND_ANGLE_BISECT: begin
				px = bx;
				py = by;
				ok = unit_vector(ax - bx, ay - by, min_len, uax, uay);
				ok2 = unit_vector(cx - bx, cy - by, min_len, ucx, ucy);
				ok = ok && ok2;
				if (ok) begin
					sumx = uax + ucx;
					sumy = uay + ucy;
					// Nearly opposite rays fall back to the normal of BA.
					if (int_sqrt(abs64(sumx) * abs64(sumx) + abs64(sumy) * abs64(sumy)) < 2)
					begin
						dx = -uay;
						dy = uax;
					end else begin
						ok = unit_vector(sumx, sumy, 0, dx, dy);
					end
				end
			end
			default: begin
				px = cx;
				py = cy;
				ok = unit_vector(bx - ax, by - ay, min_len, dx, dy);
				if (c.kind == KIND_PERP_THROUGH) begin
					t = dx; dx = -dy; dy = t;
				end
			end
		endcase
		r.ok = ok;
		r.fx = ok ? clamp32(px + dx) : '0;
		r.fy = ok ? clamp32(py + dy) : '0;
		r.sx = ok ? clamp32(px - dx) : '0;
		r.sy = ok ? clamp32(py - dy) : '0;
		return r;
	endfunction

	// Coordinate offsets of assorted magnitudes.
	function automatic logic [31:0] rand_offset();
		case ($urandom_range(4))
			0: return 32'($signed($urandom_range(6)) - 3);
			1: return 32'($signed($urandom_range(32'h40000)) - 32'sh20000);
			2: return 32'($signed($urandom_range(32'h2000000)) - 32'sh1000000);
			3: return $urandom;
			default: return 32'($signed($urandom_range(32'h400)) - 32'sh200);
		endcase
	endfunction

	function automatic logic [31:0] corner_value();
		case ($urandom_range(4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			default: return 32'h1;
		endcase
	endfunction

	function automatic construction_t random_request();
		construction_t c;
		logic [31:0] dx, dy;
		int k;
		c.kind = kind_t'($urandom_range(3));
		c.ax = $urandom; c.ay = $urandom;
		dx = rand_offset();
		dy = rand_offset();
		k = $urandom_range(1, 3);
		case ($urandom_range(9))
			4: begin
				// Opposite rays around vertex B.
				c.kind = KIND_ANGLE_BISECT;
				c.bx = c.ax - dx; c.by = c.ay - dy;
				c.cx = c.bx - dx * k; c.cy = c.by - dy * k;
			end
			5: begin
				// Rays in the same direction.
				c.bx = c.ax - dx; c.by = c.ay - dy;
				c.cx = c.bx + dx * k; c.cy = c.by + dy * k;
			end
			6: begin
				c.bx = c.ax; c.by = c.ay;
				c.cx = c.bx + rand_offset(); c.cy = c.by + rand_offset();
				if ($urandom_range(1)) begin
					c.bx = c.ax + dx; c.by = c.ay + dy;
					c.cx = c.bx; c.cy = c.by;
				end
			end
			7: begin
				c.ax = corner_value(); c.ay = corner_value();
				c.bx = corner_value(); c.by = corner_value();
				c.cx = corner_value(); c.cy = corner_value();
			end
			8, 9: begin
				c.bx = $urandom; c.by = $urandom;
				c.cx = $urandom; c.cy = $urandom;
			end
			default: begin
				c.bx = c.ax + dx; c.by = c.ay + dy;
				c.cx = c.bx + rand_offset(); c.cy = c.by + rand_offset();
			end
		endcase
		return c;
	endfunction

	function automatic construction_t make_request(input kind_t k, input logic [31:0] ax,
			ay, bx, by, cx, cy);
		construction_t c;
		c.kind = k;
		c.ax = ax; c.ay = ay; c.bx = bx; c.by = by; c.cx = cx; c.cy = cy;
		return c;
	endfunction

	task automatic drain();
		while (pending_requests.size() != 0 || s_tvalid || expected_lines.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_min_length(input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		min_len = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sender: a new item goes out when the previous one was taken or none is shown.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || took_item)) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				construction_t c;
				c = pending_requests.pop_front();
				s_tdata <= {c.cy, c.cx, c.by, c.bx, c.ay, c.ax};
				s_tuser <= c.kind;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off to back the pipeline up.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (phase_no == 1 && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Accepted requests are predicted; delivered lines are checked in order.
	always @(posedge clk) begin
		took_item <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			construction_t c;
			c.kind = kind_t'(s_tuser);
			{c.cy, c.cx, c.by, c.bx, c.ay, c.ax} = s_tdata;
			expected_lines.push_back(construct_line(c));
			kind_count[s_tuser]++;
		end
		if (arst_n && m_tvalid && m_tready) begin
			line_pts_t want;
			if (expected_lines.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected line: valid=%0b data=%h", m_tuser, m_tdata);
			end else begin
				want = expected_lines.pop_front();
				lines_checked++;
				if (!want.ok) invalid_lines++;
				if (m_tuser[0] !== want.ok || m_tdata[31:0] !== want.fx ||
						m_tdata[63:32] !== want.fy || m_tdata[95:64] !== want.sx ||
						m_tdata[127:96] !== want.sy) begin
					mismatches++;
					if (mismatches <= 10)
						$display("line %0d: expected valid=%0b %h %h %h %h, got valid=%0b %h %h %h %h",
							lines_checked, want.ok, want.fx, want.fy, want.sx, want.sy,
							m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
							m_tdata[127:96]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [15:0] settings[PHASES];
		settings = '{16'd1, 16'd0, 16'hffff, 16'($urandom_range(2, 200)), 16'd0, 16'd1,
			16'($urandom), 16'hffff};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			write_min_length(settings[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			if (p == 0) begin
				// Plain cases of every kind.
				pending_requests.push_back(make_request(KIND_PERP_BISECT, 32'h0, 32'h0,
					32'h20000, 32'h0, 32'h0, 32'h0));
				pending_requests.push_back(make_request(KIND_ANGLE_BISECT, 32'h10000, 32'h0,
					32'h0, 32'h0, 32'h0, 32'h10000));
				pending_requests.push_back(make_request(KIND_PARALLEL, 32'h0, 32'h0,
					32'h30000, 32'h40000, 32'h50000, 32'h50000));
				pending_requests.push_back(make_request(KIND_PERP_THROUGH, 32'h0, 32'h0,
					32'h30000, 32'h40000, 32'hfffb0000, 32'h50000));
				// Coincident points give a zero-length vector for each kind.
				for (int k = 0; k < 4; k++)
					pending_requests.push_back(make_request(kind_t'(k), 32'h1234, 32'h5678,
						32'h1234, 32'h5678, 32'h1234, 32'h5678));
				// Opposite rays and rays along the same line.
				pending_requests.push_back(make_request(KIND_ANGLE_BISECT, 32'h10000, 32'h0,
					32'h0, 32'h0, 32'hffff0000, 32'h0));
				pending_requests.push_back(make_request(KIND_ANGLE_BISECT, 32'h7, 32'h3,
					32'h0, 32'h0, 32'hfffffff2, 32'hfffffffa));
				pending_requests.push_back(make_request(KIND_ANGLE_BISECT, 32'h20000, 32'h0,
					32'h0, 32'h0, 32'h50000, 32'h0));
				// Components too wide for 31 bits, and odd negative midpoint sums.
				pending_requests.push_back(make_request(KIND_PERP_BISECT, 32'h80000000,
					32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0));
				pending_requests.push_back(make_request(KIND_PARALLEL, 32'h7fffffff,
					32'h80000000, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0));
				pending_requests.push_back(make_request(KIND_PERP_BISECT, 32'hffffffff,
					32'hfffffffd, 32'h0, 32'h0, 32'h0, 32'h0));
				// Coordinates that clamp at both ends of the range.
				pending_requests.push_back(make_request(KIND_PARALLEL, 32'h0, 32'h0,
					32'h10000, 32'h10000, 32'h7fffffff, 32'h80000000));
				pending_requests.push_back(make_request(KIND_PERP_THROUGH, 32'h0, 32'h0,
					32'h10000, 32'h10000, 32'h80000000, 32'h7fffffff));
				pending_requests.push_back(make_request(KIND_ANGLE_BISECT, 32'h7fffffff,
					32'h7fffffff, 32'h7fff0000, 32'h7fff0000, 32'h80000000, 32'h80000000));
				// Shortest vectors: one raw unit.
				pending_requests.push_back(make_request(KIND_PERP_THROUGH, 32'h0, 32'h0,
					32'h1, 32'h0, 32'h0, 32'h0));
				pending_requests.push_back(make_request(KIND_ANGLE_BISECT, 32'h1, 32'h1,
					32'h0, 32'h0, 32'hffffffff, 32'h1));
			end
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				pending_requests.push_back(random_request());
			drain();
			phase_no = p + 1;
		end

		$display("checked %0d lines over %0d settings (%0d invalid); kinds %0d/%0d/%0d/%0d",
			lines_checked, PHASES, invalid_lines, kind_count[0], kind_count[1],
			kind_count[2], kind_count[3]);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0 && expected_lines.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
